// ===== hdl/spq_pkg.sv =====
// Shared types, codes and defaults for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

	// Default number of entries the queue holds
	localparam int DEPTH_DEF = 16;

	// Operation codes carried in a request
	localparam logic [1:0] KIND_ENQ  = 2'd0;
	localparam logic [1:0] KIND_DEQ  = 2'd1;
	localparam logic [1:0] KIND_PEEK = 2'd2;

	// Status codes returned with every response
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// One stored entry: process id and priority number
	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
	} entry_t;

	// Request payload
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] proc_id;
		logic [7:0]  prio;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_id;
		logic [7:0]  out_prio;
		logic [4:0]  count;
	} rsp_t;

endpackage

// ===== hdl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: sequencer, entry store, response register.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_data (kind, proc_id, prio)
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_data (status, out_id, out_prio, count)
//
// One request is worked at a time; the entry store's single read port sets the pace.
// Enqueue walks from the tail toward the head, moving up to DEPTH-1 entries one slot back,
// then writes the new entry; dequeue and peek read the head; full, empty and unused kinds
// go straight to the response. The next request waits for the response register to load.
// Reset clears the sequencer state, head pointer, fill count and response valid; the store is not swept.
// A waiting response stalls the sequencer in its final state; req_ready drops meanwhile.
`timescale 1ns / 1ps
module sorted_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  spq_pkg::req_t   req_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output spq_pkg::rsp_t   rsp_data
);

	logic              res_valid;
	logic              res_take;
	spq_pkg::rsp_t     res_data;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	spq_pkg::entry_t   mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	spq_pkg::entry_t   mem_rdata;
	logic              rsp_valid_q;
	spq_pkg::rsp_t     rsp_q;

	spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_data  (res_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	spq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Move a finished result into the response register when it is free
	assign res_take = res_valid && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== hdl/spq_mem.sv =====
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module spq_mem #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  spq_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output spq_pkg::entry_t   rdata
);

	spq_pkg::entry_t mem [DEPTH];
	spq_pkg::entry_t rdata_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/spq_ctrl.sv =====
// Sequencer: head pointer, fill count and the insertion shift walk.
`timescale 1ns / 1ps
module spq_ctrl #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  spq_pkg::req_t     req_data,
	output logic              res_valid,
	input  logic              res_take,
	output spq_pkg::rsp_t     res_data,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output spq_pkg::entry_t   mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  spq_pkg::entry_t   mem_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ENQ   = 3'd1;
	localparam logic [2:0] ST_INS   = 3'd2;
	localparam logic [2:0] ST_FRONT = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]          state_q, state_d;
	logic [AW-1:0]       head_q, head_d;
	logic [CW-1:0]       held_q, held_d;
	logic [AW-1:0]       idx_q, idx_d;
	spq_pkg::req_t       op_q;
	logic [1:0]          status_q, status_d;
	spq_pkg::entry_t     front_q, front_d;
	logic                req_fire;
	spq_pkg::entry_t     new_entry;

	// Circular address: base plus offset, both below DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign new_entry = '{id: op_q.proc_id, prio: op_q.prio};

	assign res_valid         = (state_q == ST_RESP);
	assign res_data.status   = status_q;
	assign res_data.out_id   = front_q.id;
	assign res_data.out_prio = front_q.prio;
	assign res_data.count    = 5'(held_q);

	// Decode the request, walk the shift toward the head and read the front entry
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		held_d    = held_q;
		idx_d     = idx_q;
		status_d  = status_q;
		front_d   = front_q;
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = new_entry;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					status_d = spq_pkg::STAT_OK;
					front_d  = '0;
					state_d  = ST_RESP;
					if (req_data.kind == spq_pkg::KIND_ENQ) begin
						if (held_q == CW'(DEPTH)) begin
							status_d = spq_pkg::STAT_FULL;
						end else if (held_q == '0) begin
							state_d = ST_INS;
						end else begin
							// fetch the tail entry
							idx_d     = held_q[AW-1:0];
							mem_re    = 1'b1;
							mem_raddr = wrap_add(head_q, held_q[AW-1:0] - AW'(1));
							state_d   = ST_ENQ;
						end
					end else if (req_data.kind == spq_pkg::KIND_DEQ ||
						req_data.kind == spq_pkg::KIND_PEEK) begin
						if (held_q == '0) begin
							status_d = spq_pkg::STAT_EMPTY;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = head_q;
							state_d   = ST_FRONT;
						end
					end
				end
			end
			ST_ENQ: begin
				// entry at idx-1 is in mem_rdata; slot idx is free
				mem_we    = 1'b1;
				mem_waddr = wrap_add(head_q, idx_q);
				if (mem_rdata.prio >= op_q.prio) begin
					mem_wdata = mem_rdata;
					if (idx_q == AW'(1)) begin
						state_d = ST_INS;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = wrap_add(head_q, idx_q - AW'(1) - AW'(1));
						idx_d     = idx_q - AW'(1);
					end
				end else begin
					mem_wdata = new_entry;
					held_d    = held_q + CW'(1);
					state_d   = ST_RESP;
				end
			end
			ST_INS: begin
				// place the new entry at the head
				mem_we    = 1'b1;
				mem_waddr = head_q;
				mem_wdata = new_entry;
				held_d    = held_q + CW'(1);
				state_d   = ST_RESP;
			end
			ST_FRONT: begin
				front_d = mem_rdata;
				if (op_q.kind == spq_pkg::KIND_DEQ) begin
					head_d = wrap_add(head_q, AW'(1));
					held_d = held_q - CW'(1);
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			held_q  <= held_d;
		end
	end

	// Hold request and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q <= req_data;
		end
		idx_q    <= idx_d;
		status_q <= status_d;
		front_q  <= front_d;
	end

	// Fill count never exceeds the store
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(DEPTH))
		else $error("fill count above depth");

	// A shift walk only runs with room left
	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENQ || state_q == ST_INS) |-> held_q < CW'(DEPTH))
		else $error("insertion into a full store");

	// An accepted request leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != ST_IDLE)
		else $error("request accepted without progress");

	// A full report only comes with a full store
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status_q == spq_pkg::STAT_FULL) |-> held_q == CW'(DEPTH))
		else $error("full status with room left");

	// Writes happen only while an enqueue is placed
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_ENQ || state_q == ST_INS))
		else $error("store written outside insertion");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the sorted priority queue: directed, random and backpressure traffic.
`timescale 1ns / 1ps
module tb_top;

	localparam int DEPTH = spq_pkg::DEPTH_DEF;
	// Unused operation code: the block answers with no change
	localparam logic [1:0] KIND_NOP = 2'd3;
	// Cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT = 5000;
	// Length of the long receiver hold-off
	localparam int HOLD_CYCLES = 300;
	// Cycles to wait after the last response for stray ones
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	spq_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	spq_pkg::rsp_t rsp_data;

	// Shadow copy of the sorted store, front at index 0
	spq_pkg::entry_t shadow_q[$];
	// Responses predicted for accepted requests, oldest first
	spq_pkg::rsp_t pending_rsp[$];

	int mismatches = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	sorted_priority_queue_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow store and return the response it causes
	function automatic spq_pkg::rsp_t predict_response(input spq_pkg::req_t r);
		spq_pkg::rsp_t   rsp;
		spq_pkg::entry_t ent;
		int              pos;
		rsp = '0;
		rsp.status = spq_pkg::STAT_OK;
		case (r.kind) inside
			spq_pkg::KIND_ENQ: begin
				if (shadow_q.size() >= DEPTH) begin
					rsp.status = spq_pkg::STAT_FULL;
				end else begin
					// Insert ahead of every entry with equal or larger priority number
					pos = 0;
					while (pos < shadow_q.size() && shadow_q[pos].prio < r.prio)
						pos++;
					ent.id = r.proc_id;
					ent.prio = r.prio;
					shadow_q.insert(pos, ent);
				end
			end
			spq_pkg::KIND_DEQ, spq_pkg::KIND_PEEK: begin
				if (shadow_q.size() == 0) begin
					rsp.status = spq_pkg::STAT_EMPTY;
				end else begin
					rsp.out_id = shadow_q[0].id;
					rsp.out_prio = shadow_q[0].prio;
					if (r.kind == spq_pkg::KIND_DEQ)
						void'(shadow_q.pop_front());
				end
			end
			default: ;
		endcase
		rsp.count = 5'(shadow_q.size());
		return rsp;
	endfunction

	// Offer one request after a random gap, hold it until accepted, then predict
	task automatic send_request(input spq_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (!req_ready);
		pending_rsp.push_back(predict_response(r));
	endtask

	// Build a request of the given kind with random content
	function automatic spq_pkg::req_t random_request(input logic [1:0] kind);
		spq_pkg::req_t r;
		r.kind = kind;
		r.proc_id = 16'($urandom);
		// Favor a narrow priority range now and then so ties occur
		if ($urandom_range(3) == 0)
			r.prio = 8'($urandom_range(3));
		else
			r.prio = 8'($urandom);
		return r;
	endfunction

	function automatic spq_pkg::req_t make_request(input logic [1:0] kind,
			input logic [15:0] id, input logic [7:0] prio);
		spq_pkg::req_t r;
		r.kind = kind;
		r.proc_id = id;
		r.prio = prio;
		return r;
	endfunction

	// Drive the receiver: long hold-off on demand, else random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	task automatic report_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Compare each accepted response with the oldest prediction
	always @(posedge clk) begin : check_rsp
		spq_pkg::rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with none expected, actual %p", $time, rsp_data);
				mismatches++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				report_field("status", exp_rsp.status, rsp_data.status);
				report_field("out_id", exp_rsp.out_id, rsp_data.out_id);
				report_field("out_prio", exp_rsp.out_prio, rsp_data.out_prio);
				report_field("count", exp_rsp.count, rsp_data.count);
			end
		end
	end

	// End the run if no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("sorted_priority_queue_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Empty-queue cases, extremes, tie order, peek and drain
	task automatic test_directed();
		send_request(make_request(spq_pkg::KIND_DEQ, 16'hFFFF, 8'hFF));
		send_request(make_request(spq_pkg::KIND_PEEK, 16'h0000, 8'h00));
		send_request(make_request(KIND_NOP, 16'hFFFF, 8'hFF));
		send_request(make_request(spq_pkg::KIND_ENQ, 16'hFFFF, 8'hFF));
		send_request(make_request(spq_pkg::KIND_ENQ, 16'h0000, 8'h00));
		send_request(make_request(spq_pkg::KIND_ENQ, 16'h1234, 8'h80));
		send_request(make_request(spq_pkg::KIND_ENQ, 16'h5678, 8'h80));
		send_request(make_request(spq_pkg::KIND_ENQ, 16'hAAAA, 8'h80));
		send_request(make_request(spq_pkg::KIND_ENQ, 16'h5555, 8'hFF));
		send_request(make_request(spq_pkg::KIND_PEEK, 16'hFFFF, 8'hFF));
		send_request(make_request(KIND_NOP, 16'h0000, 8'h00));
		repeat (6)
			send_request(make_request(spq_pkg::KIND_DEQ, 16'h0000, 8'h00));
		send_request(make_request(spq_pkg::KIND_DEQ, 16'hFFFF, 8'hFF));
		send_request(make_request(spq_pkg::KIND_PEEK, 16'hFFFF, 8'hFF));
	endtask

	// Mix fill bursts, drain bursts and single random operations
	task automatic test_random_traffic(input int n_items);
		int sent;
		int pick;
		int burst;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(9);
			if (pick < 2) begin
				// Fill to the top and sometimes push past it
				burst = DEPTH - shadow_q.size() + $urandom_range(2);
				repeat (burst)
					send_request(random_request(spq_pkg::KIND_ENQ));
				sent += burst;
			end else if (pick < 4) begin
				// Drain toward empty with an occasional peek
				burst = shadow_q.size() + $urandom_range(2);
				repeat (burst)
					send_request(random_request(($urandom_range(4) == 0) ?
						spq_pkg::KIND_PEEK : spq_pkg::KIND_DEQ));
				sent += burst;
			end else begin
				pick = $urandom_range(99);
				if (pick < 45)
					send_request(random_request(spq_pkg::KIND_ENQ));
				else if (pick < 80)
					send_request(random_request(spq_pkg::KIND_DEQ));
				else if (pick < 95)
					send_request(random_request(spq_pkg::KIND_PEEK));
				else
					send_request(random_request(KIND_NOP));
				sent++;
			end
		end
	endtask

	// Hold off the receiver while requests keep coming so the input stalls
	task automatic test_backpressure();
		hold_token++;
		repeat (24)
			send_request(random_request(($urandom_range(3) == 0) ?
				spq_pkg::KIND_DEQ : spq_pkg::KIND_ENQ));
	endtask

	task automatic wait_drained();
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Reset, run every test in turn, then report
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();

		send_idle_pct = 0;
		rsp_stall_pct = 0;
		test_random_traffic(420);
		send_idle_pct = 64;
		rsp_stall_pct = 0;
		test_random_traffic(420);
		send_idle_pct = 0;
		rsp_stall_pct = 64;
		test_random_traffic(420);
		send_idle_pct = 26;
		rsp_stall_pct = 26;
		test_random_traffic(420);

		send_idle_pct = 0;
		rsp_stall_pct = 0;
		test_backpressure();

		req_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_priority_queue_top: match");
		else
			$display("sorted_priority_queue_top: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_mem.sv
hdl/spq_ctrl.sv
hdl/sorted_priority_queue_top.sv
test/tb_top.sv
